// ===== hw/rtl/sra_pkg.sv =====
`default_nettype none
package sra_pkg;

   localparam int TABLE_DEPTH = 128;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int PTR_W = $clog2(TABLE_DEPTH + 1);
   localparam int CMP_W = (PTR_W > 8) ? PTR_W : 8;

   localparam logic [1:0] OP_LOAD   = 2'd0;
   localparam logic [1:0] OP_XLATE  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   localparam logic [1:0] CSR_WIDE_MODE = 2'd0;
   localparam logic [1:0] CSR_SWAP      = 2'd1;
   localparam logic [1:0] CSR_SEG_COUNT = 2'd2;

   typedef struct packed {
      logic wide;
      logic swap;
   } cfg_type;

   // item moving down the cell chain
   typedef struct packed {
      logic             valid;
      logic             is_load;
      logic             is_query;
      logic [IDX_W-1:0] idx;
      logic [63:0]      ld_start;
      logic [63:0]      ld_size;
      logic [63:0]      ld_offs;
      logic [63:0]      addr;
      logic             hit;
      logic [63:0]      result;
   } item_type;

   // item between the two halves of a cell
   typedef struct packed {
      item_type    item;
      logic [63:0] diff;
      logic [63:0] seg_end;
      logic        ge;
      logic        active;
   } mid_type;

   function automatic logic [63:0] seg_view(input logic [63:0] raw, input logic wide,
                                            input logic swap);
      logic [63:0] r;
      r = '0;
      if (wide) begin
         if (swap) begin
            for (int k = 0; k < 8; k++) begin
               r[8*k +: 8] = raw[8*(7-k) +: 8];
            end
         end else begin
            r = raw;
         end
      end else begin
         if (swap) begin
            for (int k = 0; k < 4; k++) begin
               r[8*k +: 8] = raw[8*(3-k) +: 8];
            end
         end else begin
            r[31:0] = raw[31:0];
         end
      end
      return r;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/segment_range_address_translate.sv =====
// Segment table and address translator.
// req channel: one item per handshake. req_tuser holds the opcode (load entry,
// translate, clear load pointer). req_tdata holds seg_start, seg_mem_size,
// seg_file_offset and query_address. Loads fill the table in order from the
// load pointer; loads past the table depth are dropped.
// rsp channel: one item per translate, carrying file_offset in rsp_tdata and
// status in rsp_tuser (0 found, 1 not found, offset then zero).
// csr port: wide_mode, swap_bytes and segments_in_use; write only while idle.
// Items walk a chain of TABLE_DEPTH cells, one table entry per cell, two
// register stages per cell. A new item is taken every cycle unless stalled;
// an item passes an input register, the cell stages and the rsp register.
// Items keep their order, so a translate sees every load accepted before it.
// Reset clears the load pointer, the csr registers and all in-flight items; the
// table contents stay undefined until loaded.
// When rsp_tready is low with a result held, the whole chain stalls and
// req_tready drops until the result is taken.
`default_nettype none
module segment_range_address_translate (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   // seg_start[63:0], seg_mem_size[127:64], seg_file_offset[191:128],
   // query_address[255:192]
   input  wire logic [255:0] req_tdata,
   // opcode[1:0]
   input  wire logic [1:0]   req_tuser,
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   // file_offset[63:0]
   output logic [63:0]       rsp_tdata,
   // status[0]
   output logic [0:0]        rsp_tuser,
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [7:0]   csr_wdata
);
   import sra_pkg::*;

   logic                wide_ff, swap_ff;
   logic [7:0]          seg_count_ff;
   logic [PTR_W-1:0]    ptr_ff, ptr_in;
   logic                advance;
   logic                accept;
   item_type            entry_in, entry_ff;
   item_type            chain [TABLE_DEPTH+1];
   logic [TABLE_DEPTH-1:0] search_en;
   cfg_type             cfg;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [63:0]         rsp_data_ff;
   logic                rsp_status_ff;

   assign advance    = !rsp_valid_ff || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   assign cfg.wide = wide_ff;
   assign cfg.swap = swap_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wide_ff      <= 1'b0;
         swap_ff      <= 1'b0;
         seg_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_WIDE_MODE: wide_ff <= csr_wdata[0];
            CSR_SWAP:      swap_ff <= csr_wdata[0];
            CSR_SEG_COUNT: seg_count_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      ptr_in            = ptr_ff;
      entry_in          = '0;
      entry_in.ld_start = req_tdata[63:0];
      entry_in.ld_size  = req_tdata[127:64];
      entry_in.ld_offs  = req_tdata[191:128];
      entry_in.addr     = wide_ff ? req_tdata[255:192] : {32'h0, req_tdata[223:192]};
      entry_in.idx      = ptr_ff[IDX_W-1:0];
      if (accept) begin
         case (req_tuser)
            OP_LOAD: begin
               if (ptr_ff < PTR_W'(TABLE_DEPTH)) begin
                  entry_in.valid   = 1'b1;
                  entry_in.is_load = 1'b1;
                  ptr_in           = ptr_ff + 1'b1;
               end
            end
            OP_XLATE: begin
               entry_in.valid    = 1'b1;
               entry_in.is_query = 1'b1;
            end
            OP_CLEAR: ptr_in = '0;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_ff <= entry_in;
      end
      if (reset) begin
         entry_ff.valid <= 1'b0;
      end
   end

   assign chain[0] = entry_ff;

   for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
      assign search_en[i] = CMP_W'(seg_count_ff) > CMP_W'(i);

      sra_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .cell_index (IDX_W'(i)),
         .search_en  (search_en[i]),
         .cfg        (cfg),
         .item_i     (chain[i]),
         .item_o     (chain[i+1])
      );
   end

   assign rsp_valid_in = advance ? (chain[TABLE_DEPTH].valid && chain[TABLE_DEPTH].is_query)
                                 : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_data_ff   <= chain[TABLE_DEPTH].hit ? chain[TABLE_DEPTH].result : 64'h0;
         rsp_status_ff <= !chain[TABLE_DEPTH].hit;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_status_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/sra_cell.sv =====
`default_nettype none
module sra_cell (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic [sra_pkg::IDX_W-1:0] cell_index,
   input  wire logic                  search_en,
   input  wire sra_pkg::cfg_type      cfg,
   input  wire sra_pkg::item_type     item_i,
   output sra_pkg::item_type          item_o
);
   import sra_pkg::*;

   logic [63:0] start_ff, size_ff, offs_ff;
   logic        wr;
   logic [63:0] mask;
   logic [63:0] s_view, z_view, o_view;
   logic [64:0] sub;
   mid_type     mid_in, mid_ff;
   item_type    out_in, out_ff;

   assign mask = cfg.wide ? {64{1'b1}} : {32'h0, 32'hFFFF_FFFF};

   // a load ahead of a query writes here before the query arrives
   assign wr = advance && item_i.valid && item_i.is_load && (item_i.idx == cell_index);

   always_ff @(posedge clock) begin
      if (wr) begin
         start_ff <= item_i.ld_start;
         size_ff  <= item_i.ld_size;
         offs_ff  <= item_i.ld_offs;
      end
   end

   assign s_view = seg_view(start_ff, cfg.wide, cfg.swap);
   assign z_view = seg_view(size_ff, cfg.wide, cfg.swap);
   assign o_view = seg_view(offs_ff, cfg.wide, cfg.swap);

   // first half: address minus start (borrow gives the lower bound) and segment end
   assign sub = {1'b0, item_i.addr} - {1'b0, s_view};

   always_comb begin
      mid_in.item    = item_i;
      mid_in.diff    = sub[63:0];
      mid_in.seg_end = (s_view + z_view) & mask;
      mid_in.ge      = !sub[64];
      mid_in.active  = search_en && item_i.valid && item_i.is_query && !item_i.hit;
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mid_ff <= mid_in;
      end
      if (reset) begin
         mid_ff.item.valid <= 1'b0;
      end
   end

   // second half: upper bound and translated offset
   always_comb begin
      out_in = mid_ff.item;
      if (mid_ff.active && mid_ff.ge && (mid_ff.seg_end > mid_ff.item.addr)) begin
         out_in.hit    = 1'b1;
         out_in.result = (mid_ff.diff + o_view) & mask;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
      if (reset) begin
         out_ff.valid <= 1'b0;
      end
   end

   assign item_o = out_ff;

endmodule
`default_nettype wire
